[rtl/sapq_pkg.sv]
package sapq_pkg;

	// Request opcodes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// Result status codes
	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	// Fixed field widths of the channels
	localparam int PORT_PRIO_W  = 8;
	localparam int PAYLOAD_W    = 32;
	localparam int FILL_W       = 5;
	localparam int STATUS_W     = 2;

	// Command broadcast to every cell of the chain
	typedef struct packed {
		logic insert;
		logic remove;
	} cell_cmd_t;

endpackage

[rtl/sapq_if.sv]
interface sapq_req_if;
	import sapq_pkg::*;

	logic                        valid;
	logic                        ready;
	logic                        opcode;
	logic [PORT_PRIO_W-1:0]      priority_req;
	logic signed [PAYLOAD_W-1:0] payload;

	modport source(output valid, opcode, priority_req, payload, input ready);
	modport sink(input valid, opcode, priority_req, payload, output ready);
endinterface

interface sapq_res_if;
	import sapq_pkg::*;

	logic                        valid;
	logic                        ready;
	logic [STATUS_W-1:0]         status;
	logic                        out_valid;
	logic [PORT_PRIO_W-1:0]      out_priority;
	logic signed [PAYLOAD_W-1:0] out_payload;
	logic [FILL_W-1:0]           fill_count;

	modport source(output valid, status, out_valid, out_priority, out_payload, fill_count,
		input ready);
	modport sink(input valid, status, out_valid, out_priority, out_payload, fill_count,
		output ready);
endinterface

[rtl/sapq_cell.sv]
module sapq_cell #(
	parameter int PRIO_W = 8
) (
	input  logic                                  clk,
	input  sapq_pkg::cell_cmd_t                   cmd,
	input  logic                                  occupied,
	input  logic                                  prev_gt,
	input  logic [PRIO_W-1:0]                     new_prio,
	input  logic signed [sapq_pkg::PAYLOAD_W-1:0] new_payload,
	input  logic [PRIO_W-1:0]                     prev_prio,
	input  logic signed [sapq_pkg::PAYLOAD_W-1:0] prev_payload,
	input  logic [PRIO_W-1:0]                     next_prio,
	input  logic signed [sapq_pkg::PAYLOAD_W-1:0] next_payload,
	output logic [PRIO_W-1:0]                     prio_q,
	output logic signed [sapq_pkg::PAYLOAD_W-1:0] payload_q,
	output logic                                  gt
);
	import sapq_pkg::*;

	// Entry outranks the incoming one: it stays ahead of it
	assign gt = occupied && (prio_q > new_prio);

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			if (!gt) begin
				if (prev_gt) begin
					prio_q    <= new_prio;
					payload_q <= new_payload;
				end else begin
					prio_q    <= prev_prio;
					payload_q <= prev_payload;
				end
			end
		end else if (cmd.remove) begin
			prio_q    <= next_prio;
			payload_q <= next_payload;
		end
	end

endmodule

[rtl/sorted_array_priority_queue_unit.sv]
// A request's result is registered and presented in the cycle after the request is taken.
// One insert or remove is taken per cycle, whenever the result slot is empty or
// drains; the cell chain updates at the clock edge that takes the request.
// Reset (arst_n low, asynchronous): the fill count and the result valid clear;
// cell contents are left as they are and are never read until written.
module sorted_array_priority_queue_unit #(
	parameter int QUEUE_DEPTH   = 16,
	parameter int PRIORITY_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	sapq_req_if.sink   req,
	sapq_res_if.source res
);
	import sapq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// The queue is held as a chain of cells sorted descending: cell 0 is the
	// top entry. An insert keeps every cell that outranks the new entry, drops
	// the new entry into the first cell that does not, and moves the rest up
	// one cell. A remove returns cell 0 and moves every cell down one.
	// Equal priorities: the new entry goes ahead of older equals, so the last
	// inserted is removed first.

	logic [CNT_W-1:0] count_q;
	logic             accept;
	logic             is_full;
	logic             is_empty;
	logic             do_insert;
	logic             do_remove;
	cell_cmd_t        cmd;

	logic [PRIORITY_BITS-1:0] new_prio;
	logic [PRIORITY_BITS-1:0] cell_prio [QUEUE_DEPTH];
	logic signed [PAYLOAD_W-1:0] cell_payload [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]   cell_gt;

	// Result register
	logic                        res_valid_q;
	logic [STATUS_W-1:0]         status_q;
	logic                        out_valid_q;
	logic [PORT_PRIO_W-1:0]      out_priority_q;
	logic signed [PAYLOAD_W-1:0] out_payload_q;
	logic [FILL_W-1:0]           fill_count_q;
	logic [CNT_W-1:0]            count_next;
	logic [63:0]                 prio_wide;
	logic [63:0]                 top_wide;
	logic [31:0]                 count_wide;

	// Take a new request whenever the result slot is free or being drained
	assign req.ready = !res_valid_q || res.ready;
	assign accept    = req.valid && req.ready;

	assign is_full   = (count_q == CNT_W'(QUEUE_DEPTH));
	assign is_empty  = (count_q == '0);
	assign do_insert = accept && (req.opcode == OP_INSERT) && !is_full;
	assign do_remove = accept && (req.opcode == OP_REMOVE) && !is_empty;

	assign cmd.insert = do_insert;
	assign cmd.remove = do_remove;

	// Reduce the request priority to the stored width
	assign prio_wide = 64'(req.priority_req);
	assign new_prio  = prio_wide[PRIORITY_BITS-1:0];

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			logic                        prev_gt;
			logic [PRIORITY_BITS-1:0]    prev_prio;
			logic signed [PAYLOAD_W-1:0] prev_payload;
			logic [PRIORITY_BITS-1:0]    next_prio;
			logic signed [PAYLOAD_W-1:0] next_payload;
			logic                        occupied;

			assign occupied = (count_q > CNT_W'(gi));

			if (gi == 0) begin : g_head
				// Nothing ahead of the head: it takes the new entry if it does not outrank it
				assign prev_gt      = 1'b1;
				assign prev_prio    = new_prio;
				assign prev_payload = req.payload;
			end else begin : g_body
				assign prev_gt      = cell_gt[gi-1];
				assign prev_prio    = cell_prio[gi-1];
				assign prev_payload = cell_payload[gi-1];
			end

			if (gi == QUEUE_DEPTH - 1) begin : g_tail
				// Last cell becomes unused on a remove; hold its contents
				assign next_prio    = cell_prio[gi];
				assign next_payload = cell_payload[gi];
			end else begin : g_inner
				assign next_prio    = cell_prio[gi+1];
				assign next_payload = cell_payload[gi+1];
			end

			sapq_cell #(
				.PRIO_W(PRIORITY_BITS)
			) u_cell (
				.clk         (clk),
				.cmd         (cmd),
				.occupied    (occupied),
				.prev_gt     (prev_gt),
				.new_prio    (new_prio),
				.new_payload (req.payload),
				.prev_prio   (prev_prio),
				.prev_payload(prev_payload),
				.next_prio   (next_prio),
				.next_payload(next_payload),
				.prio_q      (cell_prio[gi]),
				.payload_q   (cell_payload[gi]),
				.gt          (cell_gt[gi])
			);
		end
	endgenerate

	// Advance the count
	always_comb begin
		count_next = count_q;
		if (do_insert) begin
			count_next = count_q + CNT_W'(1);
		end else if (do_remove) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	assign top_wide   = 64'(cell_prio[0]);
	assign count_wide = 32'(count_next);

	// Result valid: set on a request, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload: capture with the request
	always_ff @(posedge clk) begin
		if (accept) begin
			fill_count_q <= count_wide[FILL_W-1:0];
			if (req.opcode == OP_INSERT) begin
				status_q       <= is_full ? STATUS_FULL : STATUS_DONE;
				out_valid_q    <= 1'b0;
				out_priority_q <= '0;
				out_payload_q  <= '0;
			end else if (is_empty) begin
				status_q       <= STATUS_EMPTY;
				out_valid_q    <= 1'b0;
				out_priority_q <= '0;
				out_payload_q  <= '0;
			end else begin
				status_q       <= STATUS_DONE;
				out_valid_q    <= 1'b1;
				out_priority_q <= top_wide[PORT_PRIO_W-1:0];
				out_payload_q  <= cell_payload[0];
			end
		end
	end

	assign res.valid        = res_valid_q;
	assign res.status       = status_q;
	assign res.out_valid    = out_valid_q;
	assign res.out_priority = out_priority_q;
	assign res.out_payload  = out_payload_q;
	assign res.fill_count   = fill_count_q;

endmodule

[test/testbench.sv]
module testbench;
	import sapq_pkg::*;

	localparam int DEPTH      = 16;
	localparam int RANDOM_REQS = 800;

	typedef struct packed {
		logic                        opcode;
		logic [PORT_PRIO_W-1:0]      prio;
		logic signed [PAYLOAD_W-1:0] data;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0]         status;
		logic                        out_valid;
		logic [PORT_PRIO_W-1:0]      out_priority;
		logic signed [PAYLOAD_W-1:0] out_payload;
		logic [FILL_W-1:0]           fill_count;
	} result_t;

	logic clk = 1'b0;
	logic arst_n;

	sapq_req_if req_ch ();
	sapq_res_if res_ch ();

	sorted_array_priority_queue_unit #(
		.QUEUE_DEPTH(DEPTH),
		.PRIORITY_BITS(PORT_PRIO_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch)
	);

	// Requests waiting to be driven, and results the queue model says must come back
	request_t req_backlog[$];
	result_t  expected_results[$];

	// Shadow of the sorted array: ascending priority, top entry at index count-1
	logic [PORT_PRIO_W-1:0]      shadow_prio[DEPTH];
	logic signed [PAYLOAD_W-1:0] shadow_data[DEPTH];
	int                          shadow_count = 0;

	int total_requests = 0;
	int req_accepted   = 0;
	int mismatches     = 0;
	int send_idle_pct;
	int stall_pct;

	// Coverage tallies for the summary
	int n_inserts = 0, n_removes = 0, n_full_drops = 0, n_empty_removes = 0;
	int peak_fill = 0;

	initial forever #1 clk = ~clk;

	// Reset: drive every input to a known value while reset is held low, then release it
	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_INSERT;
		req_ch.priority_req = '0;
		req_ch.payload = '0;
		res_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Idle profile by progress: busy sender with a stalling receiver, then swapped,
	// then full rate on both sides.
	always_comb begin
		if (req_accepted < total_requests / 3) begin
			send_idle_pct = 9;
			stall_pct = 66;
		end else if (req_accepted < (2 * total_requests) / 3) begin
			send_idle_pct = 66;
			stall_pct = 9;
		end else begin
			send_idle_pct = 0;
			stall_pct = 0;
		end
	end

	// Apply one request to the shadow queue and return the result it must produce.
	function automatic result_t queue_step(logic op, logic [PORT_PRIO_W-1:0] prio,
		logic signed [PAYLOAD_W-1:0] data);
		result_t r;
		int      pos;
		r = '0;
		r.status = STATUS_DONE;
		if (op == OP_INSERT) begin
			if (shadow_count >= DEPTH) begin
				r.status = STATUS_FULL;
			end else begin
				// New entry lands above every entry of lower or equal priority
				pos = 0;
				while (pos < shadow_count && shadow_prio[pos] <= prio)
					pos++;
				for (int k = shadow_count; k > pos; k--) begin
					shadow_prio[k] = shadow_prio[k-1];
					shadow_data[k] = shadow_data[k-1];
				end
				shadow_prio[pos] = prio;
				shadow_data[pos] = data;
				shadow_count++;
			end
		end else begin
			if (shadow_count == 0) begin
				r.status = STATUS_EMPTY;
			end else begin
				shadow_count--;
				r.out_valid = 1'b1;
				r.out_priority = shadow_prio[shadow_count];
				r.out_payload = shadow_data[shadow_count];
			end
		end
		r.fill_count = shadow_count[FILL_W-1:0];
		return r;
	endfunction

	task automatic add_request(logic op, logic [PORT_PRIO_W-1:0] prio,
		logic signed [PAYLOAD_W-1:0] data);
		request_t q;
		q.opcode = op;
		q.prio = prio;
		q.data = data;
		req_backlog.push_back(q);
	endtask

	// Driver: offer the next request once the previous one is taken or none is up
	always @(posedge clk or negedge arst_n) begin
		request_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.opcode <= OP_INSERT;
			req_ch.priority_req <= '0;
			req_ch.payload <= '0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = req_backlog.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.opcode <= nxt.opcode;
				req_ch.priority_req <= nxt.prio;
				req_ch.payload <= nxt.data;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: stall at random per the current profile
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_ch.ready <= 1'b0;
		else
			res_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Monitor: check the result taken at this edge, then predict for the request taken.
	// A result accepted here always belongs to a request taken at an earlier edge.
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				got.status = res_ch.status;
				got.out_valid = res_ch.out_valid;
				got.out_priority = res_ch.out_priority;
				got.out_payload = res_ch.out_payload;
				got.fill_count = res_ch.fill_count;
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing expected: status %0d prio %0d data %h",
						$time, got.status, got.out_priority, got.out_payload);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, got.status);
						mismatches++;
					end
					if (got.out_valid !== want.out_valid) begin
						$display("%0t: out_valid expected %0d actual %0d",
							$time, want.out_valid, got.out_valid);
						mismatches++;
					end
					if (got.out_priority !== want.out_priority) begin
						$display("%0t: out_priority expected %0d actual %0d",
							$time, want.out_priority, got.out_priority);
						mismatches++;
					end
					if (got.out_payload !== want.out_payload) begin
						$display("%0t: out_payload expected %h actual %h",
							$time, want.out_payload, got.out_payload);
						mismatches++;
					end
					if (got.fill_count !== want.fill_count) begin
						$display("%0t: fill_count expected %0d actual %0d",
							$time, want.fill_count, got.fill_count);
						mismatches++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				want = queue_step(req_ch.opcode, req_ch.priority_req, req_ch.payload);
				expected_results.push_back(want);
				req_accepted++;
				if (req_ch.opcode == OP_INSERT)
					n_inserts++;
				else
					n_removes++;
				if (want.status == STATUS_FULL)
					n_full_drops++;
				if (want.status == STATUS_EMPTY)
					n_empty_removes++;
				if (shadow_count > peak_fill)
					peak_fill = shadow_count;
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int burst_left;
		int mode;
		int insert_pct;
		int pick;
		logic op;
		logic [PORT_PRIO_W-1:0] prio;
		logic signed [PAYLOAD_W-1:0] data;

		// Directed: remove from empty, fill to the brim with extremes and ties,
		// insert into a full queue, then drain the top (ties come out newest first).
		add_request(OP_REMOVE, 8'd0, 32'sd0);
		add_request(OP_INSERT, 8'd0,   32'sh8000_0000);
		add_request(OP_INSERT, 8'd255, 32'sh7fff_ffff);
		add_request(OP_INSERT, 8'd5,   32'shffff_ffff);
		add_request(OP_INSERT, 8'd5,   32'sh0000_0000);
		add_request(OP_INSERT, 8'd5,   32'sh5555_5555);
		add_request(OP_INSERT, 8'd128, 32'shaaaa_aaaa);
		add_request(OP_INSERT, 8'd0,   32'sh0000_0001);
		add_request(OP_INSERT, 8'd255, 32'sh0000_0002);
		add_request(OP_INSERT, 8'd127, 32'sh0f0f_0f0f);
		add_request(OP_INSERT, 8'd1,   32'shf0f0_f0f0);
		add_request(OP_INSERT, 8'd254, 32'sh3333_cccc);
		add_request(OP_INSERT, 8'd64,  32'shcccc_3333);
		add_request(OP_INSERT, 8'd5,   32'sh0000_00ff);
		add_request(OP_INSERT, 8'd200, 32'shff00_0000);
		add_request(OP_INSERT, 8'd3,   32'sh1234_5678);
		add_request(OP_INSERT, 8'd9,   32'sh8765_4321);
		add_request(OP_INSERT, 8'd7,   32'shdead_0001);
		repeat (6)
			add_request(OP_REMOVE, 8'hff, 32'shffff_ffff);

		// Random: bursts that lean toward filling, draining or neither, so the fill
		// level sweeps from empty to full many times. Narrow priorities force ties.
		burst_left = 0;
		insert_pct = 50;
		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(40, 8);
				mode = $urandom_range(2);
				insert_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
			end
			burst_left--;
			op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
			pick = $urandom_range(99);
			if (pick < 60)
				prio = PORT_PRIO_W'($urandom_range(7));
			else if (pick < 70)
				prio = $urandom_range(1) ? 8'd255 : 8'd0;
			else
				prio = PORT_PRIO_W'($urandom);
			pick = $urandom_range(99);
			if (pick < 5)
				data = 32'sh8000_0000;
			else if (pick < 10)
				data = 32'sh7fff_ffff;
			else
				data = $urandom;
			add_request(op, prio, data);
		end
		total_requests = req_backlog.size();

		wait (req_accepted == total_requests);
		wait (expected_results.size() == 0);
		repeat (4) @(posedge clk);

		$display("covered %0d inserts (%0d dropped on full), %0d removes (%0d on empty)",
			n_inserts, n_full_drops, n_removes, n_empty_removes);
		$display("peak fill %0d of %0d, %0d field mismatches", peak_fill, DEPTH, mismatches);
		if (mismatches == 0)
			$display("sorted_array_priority_queue_unit verification clean");
		else
			$display("sorted_array_priority_queue_unit verification failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#200000;
		$display("timeout with %0d results still expected", expected_results.size());
		$display("sorted_array_priority_queue_unit verification failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/sapq_pkg.sv
rtl/sapq_if.sv
rtl/sapq_cell.sv
rtl/sorted_array_priority_queue_unit.sv
test/testbench.sv
